[sv/wbps_pkg.sv]
// wbps_pkg: shared constants, status codes and the stage control struct
// of the wildcard byte pattern search
// no dependencies
package wbps_pkg;

  localparam int LEN_W     = 5;   // pattern length field width
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;  // pattern register width
  localparam int CFG_IDX_W = 2;   // configuration register index width
  localparam int OUT_OFF_W = 32;  // reported offset width
  localparam int PAT_BYTES = 16;  // bytes held by the two pattern registers

  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int OFFSET_BITS_DEFAULT = 32;

  typedef enum logic [1:0] {
    STATUS_FULL    = 2'd0,
    STATUS_PARTIAL = 2'd1,
    STATUS_NONE    = 2'd2,
    STATUS_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_PAT_LEN  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [LEN_W-1:0] len;
  } stage_ctrl_t;

endpackage

[sv/wbps_if.sv]
// wbps_if: handshake interfaces for the byte stream, the result stream
// and the configuration write channel
// depends on wbps_pkg
interface wbps_scan_if import wbps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface wbps_result_if import wbps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [OUT_OFF_W-1:0] match_offset;
  logic [LEN_W-1:0]     matched_length;

  modport source (output valid, status, match_offset, matched_length, input ready);
  modport sink   (input valid, status, match_offset, matched_length, output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/wildcard_byte_pattern_search_core.sv]
// wildcard_byte_pattern_search_core: top level, configuration registers,
// byte position counter, the row of candidate cells and the tracker stage
// depends on wbps_pkg, wbps_if, wbps_cell, wbps_tracker
//
// usage
//   cfg    : register writes, index 0 pattern bytes 0..7, 1 pattern bytes
//            8..15, 2 pattern length; a zero pattern byte is a wildcard
//   scan   : one buffer byte per request, last_byte marks the buffer end
//   result : one request per buffer, sent after its last byte
// throughput is one byte per cycle while scan.ready is high: every cell
// compares the new byte in parallel and registers its alive bit, which the next
// cell uses with the next accepted byte; the last byte reaches the result through
// the register after the cell row, then the tracker stage which registers the result
// reset clears the pattern, the scan state and the result register
// when the result receiver stalls, bytes keep flowing until the next last
// byte reaches the tracker; that one waits there and scan.ready drops
// until the held result is taken
module wildcard_byte_pattern_search_core import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  wbps_cfg_if.sink      cfg,
  wbps_scan_if.sink     scan,
  wbps_result_if.source result
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  // configuration registers
  logic [CFG_W-1:0]         pattern_bytes_low;
  logic [CFG_W-1:0]         pattern_bytes_high;
  logic [LEN_W-1:0]         pattern_length;
  logic [2*CFG_W-1:0]       pattern_all;
  logic [LEN_W-1:0]         act_len;

  // scan front end
  logic [OFFSET_BITS-1:0]   pos;
  logic                     accept;
  logic                     take;
  logic [MAX_PATTERN-1:0]   hits;
  logic [MAX_PATTERN-1:0]   alive;
  logic [MAX_PATTERN-1:0]   prev_alive;

  // register between the cell row and the tracker
  stage_ctrl_t              s1_ctrl;
  logic [MAX_PATTERN-1:0]   s1_hits;
  logic [OFFSET_BITS-1:0]   s1_pos;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
      pattern_length     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PAT_LOW:  pattern_bytes_low  <= cfg.data;
        CFG_PAT_HIGH: pattern_bytes_high <= cfg.data;
        CFG_PAT_LEN:  pattern_length     <= cfg.data[LEN_W-1:0];
        default:      ;  // unmapped index, write ignored
      endcase
    end
  end

  assign pattern_all = {pattern_bytes_high, pattern_bytes_low};
  // lengths above the cell count act as the cell count
  assign act_len = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : pattern_length;

  // new byte enters whenever the pipeline register is free or moving on
  assign scan.ready = !s1_ctrl.valid || take;
  assign accept     = scan.valid && scan.ready;

  // byte position saturates, cleared at the end of every buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (scan.last_byte) begin
        pos <= '0;
      end else if (pos != POS_MAX) begin
        pos <= pos + OFFSET_BITS'(1);
      end
    end
  end

  // row of candidate cells, cell k extends the matches held by cell k-1
  assign prev_alive = {alive[MAX_PATTERN-2:0], 1'b1};

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wbps_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .advance      (accept),
      .clear        (scan.last_byte),
      .enable       (LEN_W'(k) < act_len),
      .keep         (LEN_W'(k + 1) < act_len),
      .pattern_byte (pattern_all[k*BYTE_W +: BYTE_W]),
      .data_byte    (scan.data_byte),
      .prev_alive   (prev_alive[k]),
      .hit          (hits[k]),
      .alive        (alive[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl.valid <= 1'b0;
    end else if (scan.ready) begin
      s1_ctrl.valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl.last <= scan.last_byte;
      s1_ctrl.len  <= act_len;
      s1_hits      <= hits;
      s1_pos       <= pos;
    end
  end

  wbps_tracker #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (s1_ctrl),
    .hits   (s1_hits),
    .pos    (s1_pos),
    .take   (take),
    .result (result)
  );

`ifndef SYNTHESIS
  // the cell row is empty after the end of a buffer
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && scan.last_byte |=> alive == '0)
    else $error("cells still alive after last byte");

  // position only moves forwards inside a buffer
  a_pos_monotonic: assert property (@(posedge clk) disable iff (rst)
    accept && !scan.last_byte |=> pos >= $past(pos) && pos != '0)
    else $error("byte position went backwards");

  // a partial match always spans at least two bytes
  a_partial_len: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == STATUS_PARTIAL |-> result.matched_length >= LEN_W'(2))
    else $error("partial match shorter than two bytes");

  // no-match and empty results carry zero offset and length
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == STATUS_NONE || result.status == STATUS_EMPTY)
    |-> result.match_offset == '0 && result.matched_length == '0)
    else $error("no-match result carries offset or length");
`endif

endmodule

[sv/wbps_cell.sv]
// wbps_cell: one candidate cell, tracks whether some start has matched
// pattern bytes up to this cell's position
// depends on wbps_pkg
module wbps_cell import wbps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              clear,
  input  logic              enable,
  input  logic              keep,
  input  logic [BYTE_W-1:0] pattern_byte,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              prev_alive,
  output logic              hit,
  output logic              alive
);

  // zero pattern byte matches anything
  assign hit = enable && prev_alive &&
               ((pattern_byte == '0) || (pattern_byte == data_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else if (advance) begin
      alive <= clear ? 1'b0 : (hit && keep);
    end
  end

endmodule

[sv/wbps_tracker.sv]
// wbps_tracker: second stage, keeps the earliest full match and the best
// partial match and builds the result on the last byte
// depends on wbps_pkg
module wbps_tracker import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
  parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stage_ctrl_t            ctrl,
  input  logic [MAX_PATTERN-1:0] hits,
  input  logic [OFFSET_BITS-1:0] pos,
  output logic                   take,
  wbps_result_if.source          result
);

  logic                   full_seen;
  logic [OFFSET_BITS-1:0] full_off;
  logic [LEN_W-1:0]       best_len;
  logic [OFFSET_BITS-1:0] best_off;

  logic                   full_hit;
  logic [LEN_W-1:0]       longest;
  logic                   full_seen_next;
  logic [OFFSET_BITS-1:0] full_off_next;
  logic [LEN_W-1:0]       best_len_next;
  logic [OFFSET_BITS-1:0] best_off_next;
  logic                   report;
  status_t                status_next;
  logic [OUT_OFF_W-1:0]   offset_next;
  logic [LEN_W-1:0]       length_next;

  // a last byte waits while an earlier result is still held
  assign take   = ctrl.valid && (!ctrl.last || !result.valid || result.ready);
  assign report = take && ctrl.last;

  always_comb begin
    full_hit = 1'b0;
    longest  = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LEN_W'(k + 1) == ctrl.len) full_hit = hits[k];
      if (hits[k]) longest = LEN_W'(k + 1);
    end

    full_seen_next = full_seen || full_hit;
    full_off_next  = full_seen ? full_off
                               : pos - OFFSET_BITS'(ctrl.len) + OFFSET_BITS'(1);

    best_len_next = best_len;
    best_off_next = best_off;
    if (longest >= LEN_W'(2) && longest > best_len) begin
      best_len_next = longest;
      best_off_next = pos - OFFSET_BITS'(longest) + OFFSET_BITS'(1);
    end

    if (ctrl.len == '0) begin
      status_next = STATUS_EMPTY;
      offset_next = '0;
      length_next = '0;
    end else if (full_seen_next) begin
      status_next = STATUS_FULL;
      offset_next = OUT_OFF_W'(full_off_next);
      length_next = ctrl.len;
    end else if (best_len_next >= LEN_W'(2)) begin
      status_next = STATUS_PARTIAL;
      offset_next = OUT_OFF_W'(best_off_next);
      length_next = best_len_next;
    end else begin
      status_next = STATUS_NONE;
      offset_next = '0;
      length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_seen <= 1'b0;
      full_off  <= '0;
      best_len  <= '0;
      best_off  <= '0;
    end else if (take) begin
      if (ctrl.last) begin
        full_seen <= 1'b0;
        full_off  <= '0;
        best_len  <= '0;
        best_off  <= '0;
      end else begin
        full_seen <= full_seen_next;
        full_off  <= full_off_next;
        best_len  <= best_len_next;
        best_off  <= best_off_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (report) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report) begin
      result.status         <= status_next;
      result.match_offset   <= offset_next;
      result.matched_length <= length_next;
    end
  end

endmodule

[tb/sv/testbench.sv]
// testbench: self-checking bench for wildcard_byte_pattern_search_core, with a
// scoreboard class that predicts one report per buffer and checks the result channel
// depends on wbps_pkg, wbps_if and the core
import wbps_pkg::*;

typedef struct packed {
  status_t              status;
  logic [OUT_OFF_W-1:0] offset;
  logic [LEN_W-1:0]     length;
} scan_report_t;

class match_report_board;
  logic [CFG_W-1:0]               pat_lo, pat_hi;
  logic [LEN_W-1:0]               pat_len;
  logic [OFFSET_BITS_DEFAULT-1:0] position;
  logic [PAT_BYTES-1:0]           alive;
  logic [LEN_W-1:0]               best_len;
  logic [OFFSET_BITS_DEFAULT-1:0] best_off;
  bit                             full_seen;
  logic [OFFSET_BITS_DEFAULT-1:0] full_off;
  scan_report_t                   pending_reports[$];
  int unsigned                    mismatches;

  function new();
    pat_lo = '0;
    pat_hi = '0;
    pat_len = '0;
    mismatches = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    position = '0;
    alive = '0;
    best_len = '0;
    best_off = '0;
    full_seen = 1'b0;
    full_off = '0;
  endfunction

  function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    case (idx)
      CFG_PAT_LOW:  pat_lo = value;
      CFG_PAT_HIGH: pat_hi = value;
      CFG_PAT_LEN:  pat_len = value[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // advance the candidate row by one accepted byte, queue a report on the last one
  function void note_byte(logic [BYTE_W-1:0] data, logic last);
    int unsigned          span;
    int unsigned          longest;
    logic [PAT_BYTES-1:0] hit;
    logic [PAT_BYTES-1:0] carry;
    logic [BYTE_W-1:0]    want;
    scan_report_t         rep;
    span = (pat_len > MAX_PATTERN_DEFAULT) ? MAX_PATTERN_DEFAULT : pat_len;
    longest = 0;
    carry = {alive[PAT_BYTES-2:0], 1'b1};
    for (int k = 0; k < PAT_BYTES; k++) begin
      want = (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
      hit[k] = (k < span) && carry[k] && (want == '0 || want == data);
      if (hit[k]) longest = k + 1;
    end
    if (span > 0 && hit[span-1] && !full_seen) begin
      full_seen = 1'b1;
      full_off = position - (span - 1);
    end
    if (longest >= 2 && longest > best_len) begin
      best_len = LEN_W'(longest);
      best_off = position - (longest - 1);
    end
    for (int k = 0; k < PAT_BYTES; k++)
      alive[k] = hit[k] && (k + 1 < span);
    if (position != '1) position++;
    if (last) begin
      rep.offset = '0;
      rep.length = '0;
      if (span == 0) begin
        rep.status = STATUS_EMPTY;
      end else if (full_seen) begin
        rep.status = STATUS_FULL;
        rep.offset = full_off[OUT_OFF_W-1:0];
        rep.length = LEN_W'(span);
      end else if (best_len >= 2) begin
        rep.status = STATUS_PARTIAL;
        rep.offset = best_off[OUT_OFF_W-1:0];
        rep.length = best_len;
      end else begin
        rep.status = STATUS_NONE;
      end
      pending_reports = {pending_reports, rep};
      clear_scan();
    end
  endfunction

  function void check_report(logic [1:0] status, logic [OUT_OFF_W-1:0] offset,
                             logic [LEN_W-1:0] length);
    scan_report_t want;
    if (pending_reports.size() == 0) begin
      $error("unexpected result: status %0d match_offset %0d matched_length %0d",
             status, offset, length);
      mismatches++;
      return;
    end
    want = pending_reports.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, status);
      mismatches++;
    end
    if (offset !== want.offset) begin
      $error("match_offset: expected %0d, actual %0d", want.offset, offset);
      mismatches++;
    end
    if (length !== want.length) begin
      $error("matched_length: expected %0d, actual %0d", want.length, length);
      mismatches++;
    end
  endfunction

  function int unsigned outstanding();
    return pending_reports.size();
  endfunction

  function bit clean();
    return mismatches == 0 && pending_reports.size() == 0;
  endfunction
endclass

module testbench;
  import wbps_pkg::*;

  // settling wait after the last report: the pipeline registers, plus a little margin
  localparam int SETTLE_CYCLES = 4;
  // cycles without any accepted request before the run is abandoned
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_BYTES  = 800;

  typedef enum {RX_OPEN, RX_RANDOM, RX_BURSTY} rx_mode_t;

  logic clk;
  logic rst;

  wbps_cfg_if    cfg_bus();
  wbps_scan_if   scan_bus();
  wbps_result_if result_bus();

  wildcard_byte_pattern_search_core DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .scan   (scan_bus),
    .result (result_bus)
  );

  match_report_board board;

  // sender pacing
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned bytes_sent;

  // local copy of the programmed pattern, used only to shape the buffers
  logic [BYTE_W-1:0] pat_sym[PAT_BYTES];
  int unsigned       pat_span;
  logic [BYTE_W-1:0] sym_pool[4];
  logic [BYTE_W-1:0] stream_bytes[$];

  // receiver stall pattern and watchdog
  rx_mode_t    rx_mode;
  int unsigned rx_span;
  int unsigned rx_hold;
  bit          rx_low;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // configuration writes: the three registers back to back, valid dropped once
  // at the end so it is never lowered and raised in the same step
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    board.write_reg(idx, value);
  endtask

  task automatic program_pattern(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                 input logic [LEN_W-1:0] len_code);
    logic [CFG_W-1:0] len_word;
    // upper bits of the length word are junk the block should ignore
    len_word = {$urandom(), $urandom()};
    len_word[LEN_W-1:0] = len_code;
    write_reg(CFG_PAT_LOW, lo);
    write_reg(CFG_PAT_HIGH, hi);
    write_reg(CFG_PAT_LEN, len_word);
    cfg_bus.valid <= 1'b0;
    for (int k = 0; k < PAT_BYTES; k++)
      pat_sym[k] = (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
    pat_span = (len_code > MAX_PATTERN_DEFAULT) ? MAX_PATTERN_DEFAULT : len_code;
  endtask

  // random pattern drawn from a small symbol pool so prefixes overlap often
  task automatic choose_pattern();
    logic [CFG_W-1:0] lo, hi;
    logic [BYTE_W-1:0] sym;
    logic [LEN_W-1:0] len_code;
    int unsigned pick;
    for (int k = 0; k < 4; k++) sym_pool[k] = BYTE_W'($urandom_range(1, 255));
    for (int k = 0; k < PAT_BYTES; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) sym = '0;                                  // wildcard
      else if (pick < 9) sym = sym_pool[$urandom_range(0, 3)];
      else sym = BYTE_W'($urandom_range(0, 255));
      if (k < 8) lo[8*k +: 8] = sym;
      else hi[8*(k-8) +: 8] = sym;
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) len_code = '0;                                // empty pattern
    else if (pick < 12) len_code = LEN_W'($urandom_range(17, 31)); // clamps to the maximum
    else if (pick < 20) len_code = LEN_W'(MAX_PATTERN_DEFAULT);
    else if (pick < 70) len_code = LEN_W'($urandom_range(1, 6));
    else len_code = LEN_W'($urandom_range(1, 15));
    program_pattern(lo, hi, len_code);
  endtask

  // ---------------------------------------------------------------------------
  // byte stream
  // ---------------------------------------------------------------------------

  // after each accepted request: maybe close the burst and leave a gap
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        scan_bus.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
    scan_bus.valid     <= 1'b1;
    scan_bus.data_byte <= data;
    scan_bus.last_byte <= last;
    do @(posedge clk); while (!scan_bus.ready);
    board.note_byte(data, last);
    bytes_sent++;
    pace_sender();
  endtask

  // hold the stream until every report is in and the pipeline has emptied
  task automatic drain();
    scan_bus.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // send stream_bytes as one buffer; at split the pattern is swapped mid-buffer
  task automatic send_buffer(input int split);
    for (int i = 0; i < stream_bytes.size(); i++) begin
      if (i == split) begin
        drain();
        choose_pattern();
      end
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    end
  endtask

  function automatic logic [BYTE_W-1:0] noise_byte();
    if ($urandom_range(0, 3) == 0) return BYTE_W'($urandom_range(0, 255));
    return sym_pool[$urandom_range(0, 3)];
  endfunction

  // add one byte at the end of the buffer under construction
  function automatic void append_byte(input logic [BYTE_W-1:0] value);
    stream_bytes = {stream_bytes, value};
  endfunction

  // well-formed buffer: noise with whole pattern copies and cut-off prefixes
  task automatic build_buffer();
    int unsigned target;
    int unsigned cut;
    int unsigned pick;
    stream_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 75) target = $urandom_range(1, 16);
    else if (pick < 95) target = $urandom_range(17, 48);
    else target = $urandom_range(49, 120);
    while (stream_bytes.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pat_span == 0 || pick < 4) begin
        append_byte(noise_byte());
      end else if (pick < 7) begin
        for (int k = 0; k < pat_span; k++)
          append_byte(pat_sym[k] == '0 ? noise_byte() : pat_sym[k]);
      end else if (pick < 9) begin
        cut = $urandom_range(1, pat_span);
        for (int k = 0; k < cut; k++)
          append_byte(pat_sym[k] == '0 ? noise_byte() : pat_sym[k]);
      end else begin
        append_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
    // now and then a prefix runs into the buffer end
    if (pat_span > 2 && $urandom_range(0, 3) == 0) begin
      cut = $urandom_range(2, pat_span - 1);
      for (int k = 0; k < cut; k++)
        append_byte(pat_sym[k] == '0 ? noise_byte() : pat_sym[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern, checks and the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_span = $urandom_range(16, 160);
    end
    rx_span--;
    case (rx_mode)
      RX_OPEN: begin
        result_bus.ready <= 1'b1;
      end
      RX_RANDOM: begin
        result_bus.ready <= ($urandom_range(0, 9) < 6);
      end
      default: begin
        // alternate runs of stall and accept
        if (rx_hold == 0) begin
          rx_low = !rx_low;
          rx_hold = rx_low ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end
        rx_hold--;
        result_bus.ready <= !rx_low;
      end
    endcase

    if (!rst && result_bus.valid && result_bus.ready)
      board.check_report(result_bus.status, result_bus.match_offset,
                         result_bus.matched_length);

    if (rst || (scan_bus.valid && scan_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_goal;
    int          split;

    board = new();
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_PAT_LOW;
    cfg_bus.data = '0;
    scan_bus.valid = 1'b0;
    scan_bus.data_byte = '0;
    scan_bus.last_byte = 1'b0;
    result_bus.ready = 1'b0;
    rx_mode = RX_OPEN;
    rx_span = 0;
    rx_hold = 0;
    rx_low = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    gap_max = 3;
    bytes_sent = 0;
    pat_span = 0;
    for (int k = 0; k < 4; k++) sym_pool[k] = 8'h41 + k;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: pattern still empty after reset
    stream_bytes = '{8'h00};
    send_buffer(-1);

    // directed: four bytes with a wildcard in the third place
    drain();
    program_pattern(64'h0000_0000_4400_4241, 64'h0, 5'd4);
    stream_bytes = '{8'h41, 8'h42, 8'h99, 8'h44};   // full match at the start
    send_buffer(-1);
    stream_bytes = '{8'h41, 8'h41, 8'h42};          // two-byte prefix cut by the end
    send_buffer(-1);
    stream_bytes = '{8'h41, 8'hFF};                 // single byte only, no match
    send_buffer(-1);

    // directed: over-long length code, all sixteen cells, wildcards in the high word
    drain();
    program_pattern('1, 64'hFF00_FF00_FF00_FF00, '1);
    stream_bytes.delete();
    for (int k = 0; k < PAT_BYTES; k++)
      append_byte((k >= 8 && k % 2 == 0) ? 8'h5A : 8'hFF);
    send_buffer(-1);

    // random: phases of one pattern and a few buffers, pacing varied per phase;
    // every phase boundary waits for all reports before reprogramming
    random_goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_goal) begin
      drain();
      choose_pattern();
      case ($urandom_range(0, 2))
        0:       gap_max = 0;      // back-to-back requests
        1:       gap_max = 3;
        default: gap_max = 10;
      endcase
      repeat ($urandom_range(2, 8)) begin
        build_buffer();
        split = -1;
        if (stream_bytes.size() > 1 && $urandom_range(0, 9) == 0)
          split = $urandom_range(1, stream_bytes.size() - 1);
        send_buffer(split);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.clean()) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
